// File: design/lppd_pkg.sv
// shared types, constants and helpers for the length-prefixed payload deframer
package lppd_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int LENGTH_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_BYTE_IN = 2'd0,
        OP_READ    = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // "+IPD", one character per match position
    function automatic logic [7:0] hdr_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h2B;
            2'd1:    c = 8'h49;
            2'd2:    c = 8'h50;
            2'd3:    c = 8'h44;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/length_prefixed_payload_deframer_top.sv
// Modem byte stream deframer: hunts "+IPD", parses the length, buffers the payload in a ring
//
// Usage:
//   Input channel (in_valid / in_ready) carries operation and rx_byte. Operation byte-in
//   feeds one modem byte to the parser; read pops one ring byte, peek looks at the oldest
//   ring byte without popping it, clear empties the ring and drops any frame in progress.
//   Output channel (out_valid / out_ready) returns one result per request: data_byte and
//   data_valid for read and peek, the ring fill level, the payload bytes still expected
//   for the current frame, and byte_dropped when a payload byte found the ring full.
//   The ring keeps one slot empty, so it holds at most RING_DEPTH-1 bytes.
// Timing:
//   For each request, parser and ring pointers update at acceptance, the ring
//   is written or read on the same edge, and the result appears on the output register the
//   cycle after. One request per cycle is sustained; the single ring write port and
//   the registered read port each serve one access per request.
//   A stalled receiver holds the result; a new request is still taken in the cycle the
//   held result leaves (in_ready = !out_valid || out_ready).
// Reset:
//   rst_n clears parser state, ring pointers and the output valid at once; the ring
//   contents need no clearing since only bytes between head and tail are ever read.
module length_prefixed_payload_deframer_top #(
    parameter int RING_DEPTH  = lppd_pkg::RING_DEPTH_DEF,
    parameter int LENGTH_BITS = lppd_pkg::LENGTH_BITS_DEF,
    localparam int PTR_W      = $clog2(RING_DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             operation,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             data_byte,
    output logic                   data_valid,
    output logic [PTR_W-1:0]       fill_count,
    output logic [LENGTH_BITS-1:0] payload_remaining,
    output logic                   byte_dropped
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_SKIP    = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    localparam logic [PTR_W-1:0]       PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W:0]         DEPTH_EXT = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [LENGTH_BITS+3:0] LEN_MAX = {4'b0, {LENGTH_BITS{1'b1}}};

    phase_t                 phase_reg, phase_next;
    logic [1:0]             hdr_pos_reg, hdr_pos_next;
    logic [LENGTH_BITS-1:0] len_acc_reg, len_acc_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic                   out_valid_reg;
    logic                   data_valid_reg, data_valid_next;
    logic [PTR_W-1:0]       fill_reg, fill_next;
    logic [LENGTH_BITS-1:0] remain_reg;
    logic                   dropped_reg, dropped_next;

    logic                   accept;
    lppd_pkg::op_t          op;
    logic                   ring_we, ring_re;
    logic [7:0]             ring_rdata;
    logic [PTR_W-1:0]       tail_inc, head_inc;
    logic                   ring_full, ring_empty;
    logic                   is_digit;
    logic [7:0]             digit_diff;
    logic [LENGTH_BITS+3:0] len_sum;
    logic [LENGTH_BITS-1:0] bytes_dec;
    logic [PTR_W:0]         fill_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign op       = lppd_pkg::op_t'(operation);

    assign tail_inc   = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign head_inc   = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign ring_full  = (tail_inc == head_reg);
    assign ring_empty = (head_reg == tail_reg);

    assign is_digit   = (rx_byte >= lppd_pkg::CHAR_ZERO) && (rx_byte <= lppd_pkg::CHAR_NINE);
    assign digit_diff = rx_byte - lppd_pkg::CHAR_ZERO;
    // acc * 10 + digit as shifts and adds
    assign len_sum    = {1'b0, len_acc_reg, 3'b0} + {3'b0, len_acc_reg, 1'b0}
                      + {{LENGTH_BITS{1'b0}}, digit_diff[3:0]};
    assign bytes_dec  = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_pos_next    = hdr_pos_reg;
        len_acc_next    = len_acc_reg;
        bytes_left_next = bytes_left_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        data_valid_next = 1'b0;
        dropped_next    = 1'b0;
        ring_we         = 1'b0;
        ring_re         = 1'b0;

        unique case (op)
            lppd_pkg::OP_BYTE_IN:
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == lppd_pkg::hdr_char(hdr_pos_reg))
                        begin
                            if (hdr_pos_reg == 2'd3)
                            begin
                                hdr_pos_next = '0;
                                len_acc_next = '0;
                                phase_next   = PH_DIGITS;
                            end
                            else
                            begin
                                hdr_pos_next = hdr_pos_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            // a stray '+' restarts the match at its first character
                            hdr_pos_next = (rx_byte == lppd_pkg::CHAR_PLUS) ? 2'd1 : 2'd0;
                        end
                    end
                    PH_DIGITS, PH_SKIP:
                    begin
                        if (phase_reg == PH_DIGITS && is_digit)
                        begin
                            len_acc_next = (len_sum > LEN_MAX) ? LEN_MAX[LENGTH_BITS-1:0]
                                                               : len_sum[LENGTH_BITS-1:0];
                        end
                        else if (rx_byte == lppd_pkg::CHAR_COLON)
                        begin
                            bytes_left_next = len_acc_reg;
                            hdr_pos_next    = '0;
                            phase_next      = (len_acc_reg != '0) ? PH_PAYLOAD : PH_HUNT;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (ring_full)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            ring_we   = accept;
                            tail_next = tail_inc;
                        end
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == '0)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
            lppd_pkg::OP_READ, lppd_pkg::OP_PEEK:
            begin
                if (!ring_empty)
                begin
                    ring_re         = accept;
                    data_valid_next = 1'b1;
                    if (op == lppd_pkg::OP_READ)
                    begin
                        head_next = head_inc;
                    end
                end
            end
            lppd_pkg::OP_CLEAR:
            begin
                head_next       = '0;
                tail_next       = '0;
                hdr_pos_next    = '0;
                phase_next      = PH_HUNT;
                len_acc_next    = '0;
                bytes_left_next = '0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign fill_wide = (tail_next >= head_next)
                     ? {1'b0, tail_next} - {1'b0, head_next}
                     : {1'b0, tail_next} + DEPTH_EXT - {1'b0, head_next};
    assign fill_next = fill_wide[PTR_W-1:0];

    // head and tail never coincide on a read of a live entry, so no bypass is needed
    lppd_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ring_we),
        .waddr(tail_reg),
        .wdata(rx_byte),
        .re   (ring_re),
        .raddr(head_reg),
        .rdata(ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            hdr_pos_reg    <= '0;
            len_acc_reg    <= '0;
            bytes_left_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
            data_valid_reg <= 1'b0;
            fill_reg       <= '0;
            remain_reg     <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                hdr_pos_reg    <= hdr_pos_next;
                len_acc_reg    <= len_acc_next;
                bytes_left_reg <= bytes_left_next;
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                data_valid_reg <= data_valid_next;
                fill_reg       <= fill_next;
                remain_reg     <= bytes_left_next;
                dropped_reg    <= dropped_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign data_byte         = data_valid_reg ? ring_rdata : 8'h00;
    assign data_valid        = data_valid_reg;
    assign fill_count        = fill_reg;
    assign payload_remaining = remain_reg;
    assign byte_dropped      = dropped_reg;

endmodule

// File: design/lppd_ram.sv
// generic single-write, single-read ram with registered read data
module lppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/lppd_checker.sv
// port-level checks for the deframer, bound to the top level
module lppd_checker #(
    parameter int RING_DEPTH  = lppd_pkg::RING_DEPTH_DEF,
    parameter int LENGTH_BITS = lppd_pkg::LENGTH_BITS_DEF,
    localparam int PTR_W      = $clog2(RING_DEPTH)
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [1:0]             operation,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [7:0]             data_byte,
    input logic                   data_valid,
    input logic [PTR_W-1:0]       fill_count,
    input logic [LENGTH_BITS-1:0] payload_remaining,
    input logic                   byte_dropped
);

    localparam logic [PTR_W-1:0] FILL_MAX = PTR_W'(RING_DEPTH - 1);

    logic req_accept;

    assign req_accept = in_valid && in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(fill_count)
            && $stable(payload_remaining) && $stable(byte_dropped) && $stable(data_valid))
        else $error("stalled result changed");

    // every request yields a result in the next cycle; clear empties everything
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> out_valid && ((($past(operation) != lppd_pkg::OP_CLEAR))
            || (fill_count == '0 && payload_remaining == '0 && !data_valid && !byte_dropped)))
        else $error("request result missing or clear left state behind");

    // a drop only happens with a full ring and never with read data
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_dropped |-> fill_count == FILL_MAX && !data_valid)
        else $error("byte dropped while ring not full");

    // no ring byte means a zero data byte
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> data_byte == 8'h00)
        else $error("data byte nonzero without ring data");

endmodule

bind length_prefixed_payload_deframer_top lppd_checker #(
    .RING_DEPTH (RING_DEPTH),
    .LENGTH_BITS(LENGTH_BITS)
) u_lppd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .data_byte        (data_byte),
    .data_valid       (data_valid),
    .fill_count       (fill_count),
    .payload_remaining(payload_remaining),
    .byte_dropped     (byte_dropped)
);

// File: dv/length_prefixed_payload_deframer_top_tb.sv
// testbench for the length-prefixed payload deframer: random frames checked against a shadow model
`timescale 1ns / 1ps

module length_prefixed_payload_deframer_top_tb;

    localparam int ITEMS        = 1300;
    localparam int QUIET_ITEMS  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RING_SLOTS   = 64;
    localparam logic [31:0] HEADER_TEXT = "+IPD";

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_DIGITS,
        PH_SKIP,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [5:0]  fill;
        logic [15:0] remaining;
        logic        dropped;
    } reply_t;

    // tracks parser and ring state, predicts one reply per accepted request
    class deframer_shadow;
        reply_t      replies_due[$];
        int unsigned mismatches = 0;
        logic [2:0]  hdr_pos = '0;
        phase_t      phase = PH_HUNT;
        logic [15:0] len_sum = '0;
        logic [15:0] left = '0;
        logic [7:0]  ring [RING_SLOTS];
        logic [5:0]  head = '0;
        logic [5:0]  tail = '0;

        function void begin_payload();
            left = len_sum;
            phase = (left != 0) ? PH_PAYLOAD : PH_HUNT;
            hdr_pos = '0;
        endfunction

        function void take_request(lppd_pkg::op_t op, logic [7:0] b);
            reply_t      r;
            int unsigned v;
            r = '0;
            case (op)
                lppd_pkg::OP_BYTE_IN:
                begin
                    case (phase)
                        PH_HUNT:
                        begin
                            if (hdr_pos < 4 && b == HEADER_TEXT[31 - 8 * int'(hdr_pos) -: 8])
                                hdr_pos = hdr_pos + 3'd1;
                            else
                                hdr_pos = (b == lppd_pkg::CHAR_PLUS) ? 3'd1 : 3'd0;
                            if (hdr_pos == 3'd4)
                            begin
                                hdr_pos = '0;
                                len_sum = '0;
                                phase = PH_DIGITS;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (b >= lppd_pkg::CHAR_ZERO && b <= lppd_pkg::CHAR_NINE)
                            begin
                                v = int'(len_sum) * 10 + int'(b - lppd_pkg::CHAR_ZERO);
                                len_sum = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
                            end
                            else if (b == lppd_pkg::CHAR_COLON)
                                begin_payload();
                            else
                                phase = PH_SKIP;
                        end
                        PH_SKIP:
                        begin
                            if (b == lppd_pkg::CHAR_COLON)
                                begin_payload();
                        end
                        default:
                        begin
                            // one slot stays empty, so a full ring drops the byte
                            if (6'(tail + 6'd1) == head)
                                r.dropped = 1'b1;
                            else
                            begin
                                ring[tail] = b;
                                tail = tail + 6'd1;
                            end
                            if (left != 0)
                                left = left - 16'd1;
                            if (left == 0)
                                phase = PH_HUNT;
                        end
                    endcase
                end
                lppd_pkg::OP_READ, lppd_pkg::OP_PEEK:
                begin
                    if (tail != head)
                    begin
                        r.data_byte = ring[head];
                        r.data_valid = 1'b1;
                        if (op == lppd_pkg::OP_READ)
                            head = head + 6'd1;
                    end
                end
                default:
                begin
                    head = '0;
                    tail = '0;
                    hdr_pos = '0;
                    phase = PH_HUNT;
                    len_sum = '0;
                    left = '0;
                end
            endcase
            r.fill = 6'(tail - head);
            r.remaining = left;
            replies_due.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, got 0x%0h",
                         $time, got);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            compare("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            compare("data_valid", 16'(want.data_valid), 16'(got.data_valid));
            compare("fill_count", 16'(want.fill), 16'(got.fill));
            compare("payload_remaining", want.remaining, got.remaining);
            compare("byte_dropped", 16'(want.dropped), 16'(got.dropped));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [5:0]  fill_count;
    logic [15:0] payload_remaining;
    logic        byte_dropped;

    deframer_shadow shadow;
    int unsigned    requests_sent = 0;
    int unsigned    in_gap_pct = 0;
    int unsigned    out_stall_pct = 0;
    bit             quiet_tail = 1'b0;
    int unsigned    idle_cycles = 0;

    length_prefixed_payload_deframer_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .data_byte         (data_byte),
        .data_valid        (data_valid),
        .fill_count        (fill_count),
        .payload_remaining (payload_remaining),
        .byte_dropped      (byte_dropped)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // neither a digit nor ':', so it moves the parser into the skip phase
    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        c = any_byte();
        if (c == lppd_pkg::CHAR_COLON
            || (c >= lppd_pkg::CHAR_ZERO && c <= lppd_pkg::CHAR_NINE))
            c = "x";
        return c;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(lppd_pkg::op_t op, logic [7:0] b);
        if (!quiet_tail && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid = 1'b1;
        operation = op;
        rx_byte = b;
        do @(posedge clk); while (!in_ready);
        shadow.take_request(op, b);
        requests_sent++;
        if (requests_sent + QUIET_ITEMS >= ITEMS)
            quiet_tail = 1'b1;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_request(lppd_pkg::OP_BYTE_IN, s[i]);
    endtask

    task automatic send_frame(int unsigned len, bit oversize, int unsigned read_pct);
        int unsigned count;
        repeat ($urandom_range(0, 2)) send_request(lppd_pkg::OP_BYTE_IN, any_byte());
        send_text("+IPD");
        if (oversize)
        begin
            // at least six digits starting at 7 always exceeds the length range
            send_request(lppd_pkg::OP_BYTE_IN,
                         8'(lppd_pkg::CHAR_ZERO + 8'($urandom_range(7, 9))));
            repeat ($urandom_range(5, 7))
                send_request(lppd_pkg::OP_BYTE_IN,
                             8'(lppd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))));
            count = $urandom_range(1, 100);
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                send_request(lppd_pkg::OP_BYTE_IN, lppd_pkg::CHAR_ZERO);
            send_text($sformatf("%0d", len));
            count = len;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_request(lppd_pkg::OP_BYTE_IN, filler_byte());
        send_request(lppd_pkg::OP_BYTE_IN, lppd_pkg::CHAR_COLON);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < read_pct)
                send_request(($urandom_range(0, 3) == 0) ? lppd_pkg::OP_PEEK
                                                         : lppd_pkg::OP_READ, any_byte());
            send_request(lppd_pkg::OP_BYTE_IN, any_byte());
        end
        if (oversize)
            send_request(lppd_pkg::OP_CLEAR, any_byte());
    endtask

    // result side: random stall bursts, none near the end
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 149) == 0)
                out_stall_pct = (out_stall_pct == 0) ? 12 : 0;
            if (!quiet_tail && $urandom_range(0, 99) < out_stall_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_reply({data_byte, data_valid, fill_count, payload_remaining,
                                byte_dropped});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** length_prefixed_payload_deframer_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned k;
        string       hdr;
        shadow = new;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = lppd_pkg::OP_BYTE_IN;
        rx_byte = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty ring, header restart on a repeated '+', skip after a non-digit
        send_request(lppd_pkg::OP_READ, 8'hFF);
        send_request(lppd_pkg::OP_PEEK, 8'hA5);
        send_text("++IPD7x9:");
        send_request(lppd_pkg::OP_BYTE_IN, 8'h00);
        send_request(lppd_pkg::OP_BYTE_IN, 8'hFF);
        send_request(lppd_pkg::OP_BYTE_IN, lppd_pkg::CHAR_PLUS);
        send_request(lppd_pkg::OP_PEEK, 8'h00);
        send_request(lppd_pkg::OP_READ, 8'h5A);
        // clear with a frame still open
        send_request(lppd_pkg::OP_CLEAR, 8'hC3);
        send_request(lppd_pkg::OP_READ, 8'h3C);
        send_text("+IPD0:");

        while (requests_sent < ITEMS)
        begin
            in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_frame(($urandom_range(0, 99) < 70) ? $urandom_range(0, 12)
                                                         : $urandom_range(30, 90),
                           1'b0, ($urandom_range(0, 1) == 0) ? 0 : 30);
            else if (pick < 60)
                send_frame(0, 1'b1, ($urandom_range(0, 2) == 0) ? 30 : 0);
            else if (pick < 78)
                repeat ($urandom_range(1, 40))
                    send_request(($urandom_range(0, 4) == 0) ? lppd_pkg::OP_PEEK
                                                             : lppd_pkg::OP_READ,
                                 any_byte());
            else if (pick < 88)
            begin
                // header cut short, then junk
                hdr = "+IPD";
                k = $urandom_range(1, 3);
                send_text(hdr.substr(0, k - 1));
                repeat ($urandom_range(1, 3)) send_request(lppd_pkg::OP_BYTE_IN, any_byte());
            end
            else if (pick < 96)
                repeat ($urandom_range(1, 8))
                    send_request(lppd_pkg::op_t'(2'($urandom_range(0, 2))), any_byte());
            else
                send_request(lppd_pkg::OP_CLEAR, any_byte());
        end
        in_valid = 1'b0;

        while (shadow.replies_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
            $display("** length_prefixed_payload_deframer_top: PASSED **");
        else
            $display("** length_prefixed_payload_deframer_top: FAILED **");
        $finish;
    end

endmodule
